>>> rtl/core/pwsr_pkg.sv
// Shared types and constants for the pulse-width serial byte receiver.
// No dependencies; used by pwsr_decode and the top level.
package pwsr_pkg;

    localparam int FRAME_BYTES = 32;
    localparam int TIME_BITS   = 32;
    localparam int CNT_W       = $clog2(FRAME_BYTES);
    localparam int IDX_W       = 5;
    localparam int BYTE_W      = 8;
    localparam int BITPOS_W    = 3;

    localparam logic [BITPOS_W-1:0] BIT_LAST  = BITPOS_W'(BYTE_W - 1);
    localparam logic [CNT_W-1:0]    SLOT_LAST = CNT_W'(FRAME_BYTES - 1);

    typedef logic [TIME_BITS-1:0] tick_t;

    typedef struct packed {
        logic  reset_n;
        logic  line_level;
        tick_t timestamp;
    } sample_t;

    typedef struct packed {
        logic                prev_level;
        tick_t               last_edge;
        tick_t               low_dur;
        logic                started;
        logic [BITPOS_W-1:0] bit_pos;
        logic [BYTE_W-1:0]   shift_byte;
        logic [CNT_W-1:0]    byte_cnt;
    } rx_state_t;

    typedef struct packed {
        logic [BYTE_W-1:0] byte_value;
        logic [IDX_W-1:0]  byte_index;
        logic              frame_done;
    } result_t;

endpackage

>>> rtl/core/pwsr_decode.sv
// Combinational edge detector and bit decoder: next receiver state and result.
// Depends on pwsr_pkg.
module pwsr_decode
    import pwsr_pkg::*;
(
    input  sample_t   sample,
    input  rx_state_t cur,
    output rx_state_t nxt,
    output logic      res_valid,
    output result_t   res
);

    tick_t               elapsed;
    logic                fall;
    logic                rise;
    logic                bit_val;
    logic [BITPOS_W-1:0] shift_idx;
    logic [BYTE_W-1:0]   new_byte;
    logic                slot_last;

    always_comb begin
        elapsed   = sample.timestamp - cur.last_edge;
        fall      = !sample.line_level && cur.prev_level;
        rise      = sample.line_level && !cur.prev_level;
        // Equal durations decode as a 0 bit.
        bit_val   = cur.low_dur > elapsed;
        shift_idx = BIT_LAST - cur.bit_pos;
        new_byte  = cur.shift_byte;
        new_byte[shift_idx] = bit_val;
        slot_last = cur.byte_cnt == SLOT_LAST;

        nxt        = cur;
        res_valid  = 1'b0;
        res.byte_value = new_byte;
        res.byte_index = IDX_W'(cur.byte_cnt);
        res.frame_done = slot_last;

        if (!sample.reset_n) begin
            nxt.byte_cnt   = '0;
            nxt.bit_pos    = '0;
            nxt.started    = 1'b0;
            nxt.prev_level = sample.line_level;
            nxt.last_edge  = sample.timestamp;
        end else begin
            if (fall) begin
                nxt.last_edge = sample.timestamp;
                if (cur.started) begin
                    nxt.shift_byte = new_byte;
                    nxt.bit_pos    = cur.bit_pos + BITPOS_W'(1);
                    if (cur.bit_pos == BIT_LAST) begin
                        res_valid = 1'b1;
                        if (slot_last) begin
                            // Frame wrapped: a fresh rising edge is needed to rearm.
                            nxt.byte_cnt = '0;
                            nxt.started  = 1'b0;
                        end else begin
                            nxt.byte_cnt = cur.byte_cnt + CNT_W'(1);
                        end
                    end
                end
            end else if (rise) begin
                nxt.low_dur   = elapsed;
                nxt.last_edge = sample.timestamp;
                nxt.started   = 1'b1;
            end
            nxt.prev_level = sample.line_level;
        end
    end

endmodule

>>> rtl/core/pulse_width_serial_byte_receiver.sv
// Top level of the pulse-width serial byte receiver: sample register,
// receiver state, result register. Depends on pwsr_pkg and pwsr_decode.
//
//   Channel | Direction | Transaction payload
//   s_      | input     | reset_n, line_level, timestamp (one line sample)
//   m_      | output    | byte_value, byte_index, frame_done (one decoded byte)
//
// A sample is registered in in_sample_reg on acceptance and decoded from there
// into out_res_reg, which drives m_; a stall on m_ can keep it waiting in in_sample_reg.
// One sample per cycle is sustained unless m_ stalls: decode advances only when the
// result register is empty or draining, so m_ready low on a held byte holds the input.
// aresetn (synchronous, active low) clears all receiver state and both stages' valid flags.
module pulse_width_serial_byte_receiver
    import pwsr_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  logic              s_reset_n,
    input  logic              s_line_level,
    input  tick_t             s_timestamp,
    output logic              m_valid,
    input  logic              m_ready,
    output logic [BYTE_W-1:0] m_byte_value,
    output logic [IDX_W-1:0]  m_byte_index,
    output logic              m_frame_done
);

    logic      in_valid_reg;
    sample_t   in_sample_reg;
    rx_state_t state_reg;
    rx_state_t state_next;
    logic      out_valid_reg;
    result_t   out_res_reg;
    logic      res_valid;
    result_t   res;
    logic      advance;

    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;

    pwsr_decode u_decode (
        .sample    (in_sample_reg),
        .cur       (state_reg),
        .nxt       (state_next),
        .res_valid (res_valid),
        .res       (res)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_sample_reg.reset_n    <= s_reset_n;
            in_sample_reg.line_level <= s_line_level;
            in_sample_reg.timestamp  <= s_timestamp;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= '0;
        end else if (advance) begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= res_valid;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance && res_valid) begin
            out_res_reg <= res;
        end
    end

    assign m_valid      = out_valid_reg;
    assign m_byte_value = out_res_reg.byte_value;
    assign m_byte_index = out_res_reg.byte_index;
    assign m_frame_done = out_res_reg.frame_done;

    // A byte flagged frame_done always sits in the last slot of the frame.
    a_frame_done_slot: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg && out_res_reg.frame_done |-> out_res_reg.byte_index == IDX_W'(SLOT_LAST))
        else $error("frame_done set on a byte that is not in the last slot");

    // A sample with the device reset low never produces a byte.
    a_reset_no_byte: assert property (@(posedge aclk) disable iff (!aresetn)
        advance && !in_sample_reg.reset_n |=> !out_valid_reg)
        else $error("byte produced by a reset sample");

    // Bits are only collected while armed.
    a_bits_need_start: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg.bit_pos != '0 |-> state_reg.started)
        else $error("partial byte held while receiver not started");

endmodule
